[design/lsla_pkg.sv]
// shared constants for the light sensor luma average block
// no dependencies
package lsla_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned FULL_W   = 12;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned LUMA_W   = 8;

  localparam logic [COEF_W-1:0] COEF_R = 16'd13933;
  localparam logic [COEF_W-1:0] COEF_G = 16'd46871;
  localparam logic [COEF_W-1:0] COEF_B = 16'd4732;

  localparam int unsigned LUMA_SCALE_SH = 2;
  localparam int unsigned LUMA_MAX      = 255;
  localparam logic [PCT_W-1:0] PERCENT  = 7'd100;
  localparam logic [FULL_W-1:0] MAX_LIGHT_RESET = 12'd1023;

  // quotient bits produced by the divider before saturation
  localparam int unsigned QBITS  = 7;
  localparam int unsigned STEP_W = 3;

endpackage

[design/lsla_fifo.sv]
// small register queue used between front, back and the result port
// no dependencies
module lsla_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  fifo_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = fifo_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wptr_q] <= data_i;
    end
  end

endmodule

[design/lsla_front.sv]
// front part: luma per pixel and running sum / count of the patch
// depends on lsla_pkg
module lsla_front #(
  parameter int unsigned MAX_PIXELS = 4096,
  parameter int unsigned SW         = 22,
  parameter int unsigned CW         = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [lsla_pkg::PIX_W-1:0] red_i,
  input  logic [lsla_pkg::PIX_W-1:0] green_i,
  input  logic [lsla_pkg::PIX_W-1:0] blue_i,
  input  logic                      last_pixel_i,
  output logic                      full_o,
  output logic                      patch_push_o,
  output logic [SW+CW-1:0]          patch_o,
  input  logic                      patch_full_i
);

  localparam int unsigned PROD_W = lsla_pkg::COEF_W + lsla_pkg::PIX_W;

  logic [PROD_W+1:0]              wsum;
  logic [lsla_pkg::LUMA_W-1:0]    luma;
  logic [lsla_pkg::LUMA_W-1:0]    luma_q;
  logic                           s1_valid_q, s1_last_q;
  logic                           stall, advance, accept;
  logic [SW-1:0]                  sum_q, sum_d, sum_inc;
  logic [CW-1:0]                  cnt_q, cnt_d, cnt_inc;
  logic                           room;

  // weighted channel sum, weights add to 2^16
  assign wsum = (PROD_W+2)'(lsla_pkg::COEF_R * PROD_W'(red_i))
              + (PROD_W+2)'(lsla_pkg::COEF_G * PROD_W'(green_i))
              + (PROD_W+2)'(lsla_pkg::COEF_B * PROD_W'(blue_i));
  assign luma = (wsum[PROD_W+1:lsla_pkg::COEF_W] > (PROD_W+2-lsla_pkg::COEF_W)'(lsla_pkg::LUMA_MAX))
              ? lsla_pkg::LUMA_W'(lsla_pkg::LUMA_MAX)
              : wsum[lsla_pkg::COEF_W +: lsla_pkg::LUMA_W];

  // a last pixel waits in stage one until the patch queue has room
  assign stall   = s1_valid_q && s1_last_q && patch_full_i;
  assign full_o  = stall;
  assign accept  = push_i && !stall;
  assign advance = s1_valid_q && !stall;

  assign room    = (cnt_q < CW'(MAX_PIXELS));
  assign sum_inc = room ? sum_q + SW'({luma_q, {lsla_pkg::LUMA_SCALE_SH{1'b0}}}) : sum_q;
  assign cnt_inc = room ? cnt_q + 1'b1 : cnt_q;

  assign patch_push_o = advance && s1_last_q;
  assign patch_o      = {sum_inc, cnt_inc};

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (advance) begin
      if (s1_last_q) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_inc;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (!stall) begin
        s1_valid_q <= accept;
      end
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      luma_q    <= luma;
      s1_last_q <= last_pixel_i;
    end
  end

endmodule

[design/lsla_divider.sv]
// back part: percent = sum*100 / (count*full), restoring division, saturated
// depends on lsla_pkg
module lsla_divider #(
  parameter int unsigned SW = 22,
  parameter int unsigned CW = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        patch_empty_i,
  input  logic [SW+CW-1:0]            patch_i,
  output logic                        patch_pop_o,
  input  logic [lsla_pkg::FULL_W-1:0] full_scale_i,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output logic [lsla_pkg::PCT_W-1:0]  res_o
);

  localparam int unsigned NW = SW + lsla_pkg::PCT_W;
  localparam int unsigned DW = CW + lsla_pkg::FULL_W;
  localparam int unsigned EW = (NW > DW + lsla_pkg::QBITS) ? NW : DW + lsla_pkg::QBITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [SW-1:0]                     sum_q;
  logic [CW-1:0]                     cnt_q;
  logic [EW-1:0]                     rem_q, rem_d;
  logic [DW-1:0]                     den_q, den_d;
  logic [lsla_pkg::QBITS-1:0]        quo_q, quo_d;
  logic                              sat_q, sat_d;
  logic [lsla_pkg::STEP_W-1:0]       step_q, step_d;
  logic [EW-1:0]                     shifted;
  logic                              take;

  assign take        = (state_q == ST_IDLE) && !patch_empty_i && !res_full_i;
  assign patch_pop_o = take;
  assign shifted     = EW'(den_q) << step_q;
  assign res_push_o  = (state_q == ST_DONE);
  assign res_o       = (sat_q || (quo_q > lsla_pkg::PERCENT)) ? lsla_pkg::PERCENT : quo_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    sat_d   = sat_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        rem_d   = EW'(sum_q * NW'(lsla_pkg::PERCENT));
        den_d   = DW'(cnt_q) * DW'(full_scale_i);
        quo_d   = '0;
        sat_d   = 1'b0;
        step_d  = lsla_pkg::STEP_W'(lsla_pkg::QBITS);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_q >= shifted) begin
          rem_d = rem_q - shifted;
          // top step only tells whether the quotient reaches 128
          if (step_q == lsla_pkg::STEP_W'(lsla_pkg::QBITS)) begin
            sat_d = 1'b1;
          end else begin
            quo_d[step_q] = 1'b1;
          end
        end
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sum_q <= patch_i[CW +: SW];
      cnt_q <= patch_i[CW-1:0];
    end
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    sat_q  <= sat_d;
    step_q <= step_d;
  end

endmodule

[design/light_sensor_luma_average.sv]
// top level of the light sensor luma average block
// depends on lsla_pkg, lsla_fifo, lsla_front, lsla_divider
//
// usage:
// - pixels enter through a queue-style port: a request is taken when push is
//   high and full is low; red_i/green_i/blue_i carry the color, last_pixel_i
//   closes the sensor patch
// - each pixel is weighted to Rec.709 luma, four times the luma is summed and
//   the pixels counted (at most MAX_PIXELS of them per patch)
// - a closing pixel hands sum and count to the divider through a two-entry
//   patch queue and clears the running state at once
// - results leave through a two-entry queue: light_percent_o is valid while
//   empty is low and is taken when pop is high
// - throughput: one pixel per cycle; full rises only while a closing pixel
//   waits for room in the patch queue
// - the divider handles one patch at a time (pop, multiply, 8 compare/subtract
//   steps, write) and pushes its result into the result queue
// - a stalled result side fills the result queue, then the divider waits,
//   then the patch queue fills and finally full holds off new pixels
// - cfg_we_i writes max_light_value (reset 1023); write it only while idle
// - reset clears sums, counts, queues and the divider; no clearing pass
module light_sensor_luma_average #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [lsla_pkg::PIX_W-1:0]  red_i,
  input  logic [lsla_pkg::PIX_W-1:0]  green_i,
  input  logic [lsla_pkg::PIX_W-1:0]  blue_i,
  input  logic                        last_pixel_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [lsla_pkg::PCT_W-1:0]  light_percent_o,
  input  logic                        cfg_we_i,
  input  logic [lsla_pkg::FULL_W-1:0] cfg_wdata_i
);

  // sum grows by at most 4*255 per pixel
  localparam int unsigned SW = $clog2(MAX_PIXELS * 1020 + 1);
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

  logic [lsla_pkg::FULL_W-1:0] max_light_q;

  // front to patch queue
  logic             patch_push, patch_full, patch_pop, patch_empty;
  logic [SW+CW-1:0] patch_wdata, patch_rdata;

  // divider to result queue
  logic                       res_push, res_full;
  logic [lsla_pkg::PCT_W-1:0] res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_light_q <= lsla_pkg::MAX_LIGHT_RESET;
    end else if (cfg_we_i) begin
      max_light_q <= cfg_wdata_i;
    end
  end

  lsla_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .SW         (SW),
    .CW         (CW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .full_o       (full),
    .patch_push_o (patch_push),
    .patch_o      (patch_wdata),
    .patch_full_i (patch_full)
  );

  // patch queue lets the front keep streaming while the divider works
  lsla_fifo #(
    .W     (SW + CW),
    .DEPTH (2)
  ) u_patch_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (patch_push),
    .data_i  (patch_wdata),
    .full_o  (patch_full),
    .pop_i   (patch_pop),
    .data_o  (patch_rdata),
    .empty_o (patch_empty)
  );

  lsla_divider #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .patch_empty_i (patch_empty),
    .patch_i       (patch_rdata),
    .patch_pop_o   (patch_pop),
    .full_scale_i  (max_light_q),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_data)
  );

  // result queue parts the divider from a stalling receiver
  lsla_fifo #(
    .W     (lsla_pkg::PCT_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (light_percent_o),
    .empty_o (empty)
  );

  // results stay within percent range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (light_percent_o <= lsla_pkg::PERCENT))
    else $error("light percent above 100");

  // input back-pressure only comes from a full patch queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> patch_full)
    else $error("full without a full patch queue");

  // the divider never writes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result lost at full result queue");

  // a patch handed over is never dropped at the patch queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    patch_push |-> !patch_full)
    else $error("patch lost at full patch queue");

endmodule

[tb/tb_top.sv]
// testbench for light_sensor_luma_average: directed table, one over-long patch, random patches
// depends on lsla_pkg and the light_sensor_luma_average rtl
`timescale 1ns / 100ps

module tb_top;

  // patch length limit the dut is built with
  localparam int unsigned PATCH_MAX = 4096;
  // Q16 Rec.709 weights, kept here so the predictor stands on its own
  localparam int unsigned WEIGHT_R = 13933;
  localparam int unsigned WEIGHT_G = 46871;
  localparam int unsigned WEIGHT_B = 4732;
  // settle time before a register write, with margin over one patch in the divider
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned ITEMS_PER_SETTING = 105;

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_SET_FULL
  } row_kind_e;

  // one line of the directed plan; pct is only meaningful when typed is set
  typedef struct packed {
    row_kind_e                   kind;
    logic [lsla_pkg::FULL_W-1:0] full_scale;
    logic [lsla_pkg::PIX_W-1:0]  red;
    logic [lsla_pkg::PIX_W-1:0]  green;
    logic [lsla_pkg::PIX_W-1:0]  blue;
    logic                        last;
    logic                        typed;
    logic [lsla_pkg::PCT_W-1:0]  pct;
  } plan_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        push;
  logic                        full;
  logic [lsla_pkg::PIX_W-1:0]  red;
  logic [lsla_pkg::PIX_W-1:0]  green;
  logic [lsla_pkg::PIX_W-1:0]  blue;
  logic                        last_pixel;
  logic                        empty;
  logic                        pop;
  logic [lsla_pkg::PCT_W-1:0]  light_percent;
  logic                        cfg_we;
  logic [lsla_pkg::FULL_W-1:0] cfg_wdata;

  // predictor state: running luma sum, pixel count and the full-scale register
  int unsigned                 luma_sum;
  int unsigned                 luma_count;
  logic [lsla_pkg::FULL_W-1:0] full_scale;
  logic [lsla_pkg::PCT_W-1:0]  percent_q[$];
  logic [lsla_pkg::PCT_W-1:0]  want_pct;

  int                 send_idle_pct;
  int                 take_idle_pct;
  int                 errors;
  int                 pixels_sent;
  int                 patches_checked;
  int                 settings_used;

  // directed plan: channel extremes, single-color pixels, alternating bit patterns,
  // the register at its range ends, at zero and below its range (saturation)
  plan_row_t directed_plan [22] = '{
    '{ROW_PIXEL,    12'd0,    8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 7'd99},
    '{ROW_PIXEL,    12'd0,    8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd0,   8'd0,   8'd255, 1'b1, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'hAA,  8'h55,  8'hAA,  1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'h55,  8'hAA,  8'h55,  1'b1, 1'b0, 7'd0},
    '{ROW_SET_FULL, 12'd1020, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 7'd100},
    '{ROW_SET_FULL, 12'd4095, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 7'd24},
    '{ROW_PIXEL,    12'd0,    8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 7'd0},
    '{ROW_SET_FULL, 12'd0,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd17,  8'd200, 8'd3,   1'b1, 1'b1, 7'd100},
    '{ROW_SET_FULL, 12'd1,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 7'd100},
    '{ROW_PIXEL,    12'd0,    8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 7'd0},
    '{ROW_SET_FULL, 12'hAAA,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd128, 8'd64,  8'd32,  1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd1,   8'd2,   8'd3,   1'b1, 1'b0, 7'd0},
    '{ROW_SET_FULL, 12'h555,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL,    12'd0,    8'd200, 8'd100, 8'd50,  1'b1, 1'b0, 7'd0}
  };

  light_sensor_luma_average #(
    .MAX_PIXELS(PATCH_MAX)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .last_pixel_i    (last_pixel),
    .empty           (empty),
    .pop             (pop),
    .light_percent_o (light_percent),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Rec.709 luma in Q16, clipped to a byte (the weights sum to 65536, so it never clips)
  function automatic int unsigned rec709_luma(logic [lsla_pkg::PIX_W-1:0] r,
                                              logic [lsla_pkg::PIX_W-1:0] g,
                                              logic [lsla_pkg::PIX_W-1:0] b);
    int unsigned y;
    y = (WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b) >> 16;
    return (y > 255) ? 255 : y;
  endfunction

  // floor(sum*100 / (count*full)), saturated at 100; zero register or empty patch reads 100
  function automatic logic [lsla_pkg::PCT_W-1:0] patch_percent(int unsigned sum,
                                                               int unsigned count,
                                                               logic [lsla_pkg::FULL_W-1:0] fs);
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    if (fs == 0 || count == 0) return 7'd100;
    num = longint'(sum) * 100;
    den = longint'(count) * longint'(fs);
    quo = num / den;
    return (quo > 100) ? 7'd100 : quo[lsla_pkg::PCT_W-1:0];
  endfunction

  // mostly uniform channel values, with a bias toward the two extremes
  function automatic logic [lsla_pkg::PIX_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return lsla_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly inside the legal range, sometimes its ends, sometimes below it (down to zero)
  function automatic logic [lsla_pkg::FULL_W-1:0] random_full_scale();
    case ($urandom_range(0, 9))
      0:       return 12'd1020;
      1:       return 12'd4095;
      2:       return lsla_pkg::FULL_W'($urandom_range(0, 1019));
      default: return lsla_pkg::FULL_W'($urandom_range(1020, 4095));
    endcase
  endfunction

  // offer one pixel request and wait for it to be taken, then run the predictor;
  // typed rows push the hand-written percent instead of the predicted one
  task automatic send_pixel(logic [lsla_pkg::PIX_W-1:0] r, logic [lsla_pkg::PIX_W-1:0] g,
                            logic [lsla_pkg::PIX_W-1:0] b, logic last, logic typed,
                            logic [lsla_pkg::PCT_W-1:0] pct);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    red        <= r;
    green      <= g;
    blue       <= b;
    last_pixel <= last;
    // full is read before the edge updates it, so this edge is the one that takes the request
    do @(posedge clk); while (full);
    pixels_sent++;
    // pixels past the patch limit are dropped, but their last mark still closes the patch
    if (luma_count < PATCH_MAX) begin
      luma_sum   += 4 * rec709_luma(r, g, b);
      luma_count += 1;
    end
    if (last) begin
      percent_q.push_back(typed ? pct : patch_percent(luma_sum, luma_count, full_scale));
      luma_sum   = 0;
      luma_count = 0;
    end
  endtask

  // hold off new pixels until every pending patch result has been taken
  task automatic wait_drain();
    push <= 1'b0;
    do @(posedge clk); while (percent_q.size() != 0);
  endtask

  // register writes only go in while the block is idle
  task automatic set_full_scale(logic [lsla_pkg::FULL_W-1:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    full_scale  = value;
    settings_used++;
  endtask

  // result side: take a result whenever pop and not empty held before the edge
  always @(posedge clk) begin
    if (pop && !empty) begin
      if (percent_q.size() == 0) begin
        errors++;
        $display("%0t: light_percent %0d with no patch pending", $time, light_percent);
      end else begin
        want_pct = percent_q.pop_front();
        patches_checked++;
        if (light_percent !== want_pct) begin
          errors++;
          $display("%0t: light_percent mismatch, expected %0d, actual %0d",
                   $time, want_pct, light_percent);
        end
      end
    end
    pop <= rst_n && ($urandom_range(0, 99) >= take_idle_pct);
  end

  // run limit, far beyond the slowest passing run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int patch_len;
    int sent;
    clk             = 1'b0;
    rst_n           = 1'b0;
    push            = 1'b0;
    red             = '0;
    green           = '0;
    blue            = '0;
    last_pixel      = 1'b0;
    pop             = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    luma_sum        = 0;
    luma_count      = 0;
    full_scale      = 12'd1023;
    errors          = 0;
    pixels_sent     = 0;
    patches_checked = 0;
    settings_used   = 0;
    send_idle_pct   = 27;
    take_idle_pct   = 72;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, starting from the reset value of the register
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_SET_FULL) begin
        set_full_scale(directed_plan[i].full_scale);
      end else begin
        send_pixel(directed_plan[i].red, directed_plan[i].green, directed_plan[i].blue,
                   directed_plan[i].last, directed_plan[i].typed, directed_plan[i].pct);
      end
    end

    // patch longer than the limit: a full patch of white reads exactly 100 at 1020,
    // the dark pixels past the limit would pull it down if they were counted
    set_full_scale(12'd1020);
    for (int k = 0; k < PATCH_MAX + 4; k++) begin
      if (k < PATCH_MAX) begin
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 7'd0);
      end else begin
        send_pixel(8'd0, 8'd0, 8'd0, k == PATCH_MAX + 3, 1'b1, 7'd100);
      end
    end

    // random patches: receiver-heavy idling, sender-heavy idling, then none
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 27;
          take_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          take_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        set_full_scale(random_full_scale());
        sent = 0;
        while (sent < ITEMS_PER_SETTING) begin
          // mostly short patches, now and then a longer one
          patch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(1, 12);
          for (int k = 0; k < patch_len; k++) begin
            send_pixel(random_channel(), random_channel(), random_channel(),
                       k == patch_len - 1, 1'b0, 7'd0);
          end
          sent += patch_len;
          // occasionally let the result side run dry before the next patch
          if ($urandom_range(0, 7) == 0) wait_drain();
        end
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (percent_q.size() != 0) begin
      errors++;
      $display("%0t: %0d patch results never arrived", $time, percent_q.size());
    end

    $display("run covered %0d pixels in %0d patches over %0d full-scale settings",
             pixels_sent, patches_checked, settings_used);
    $display("including an over-long patch, a zero register and a register below range");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
